>>> hw/rtl/kbm_pkg.sv
package kbm_pkg;

    localparam int MAC_BYTES = 16;
    localparam int POS_W     = $clog2(MAC_BYTES);
    localparam int UPC_W     = 4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_KSUM,
        OP_SCHED,
        OP_ALIGN,
        OP_DATA,
        OP_FINAL,
        OP_OUT,
        OP_UNKEY
    } dp_op_t;

    // sequencing conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_WAIT_ITEM,
        C_KEYED,
        C_END,
        C_HD_NZ,
        C_LOOP,
        C_OUT_LOOP
    } cond_t;

    // loop lengths
    typedef enum logic [1:0] {
        LIM_BYTES,
        LIM_SCHED,
        LIM_FINAL
    } lim_t;

    typedef struct packed {
        dp_op_t            op;
        cond_t             cond;
        lim_t              lim;
        logic [UPC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        dp_op_t      op;
        logic [7:0]  n8;
        logic        last;
        logic        take;
    } dp_ctrl_t;

    typedef struct packed {
        logic  keyed;
        kind_t kind;
        logic  hd_zero;
        logic  out_stall;
    } dp_status_t;

    // program addresses
    localparam logic [UPC_W-1:0] A_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] A_CHKKEY   = 4'd1;
    localparam logic [UPC_W-1:0] A_LOAD     = 4'd2;
    localparam logic [UPC_W-1:0] A_KSUM     = 4'd3;
    localparam logic [UPC_W-1:0] A_SCHED    = 4'd4;
    localparam logic [UPC_W-1:0] A_ALIGN0   = 4'd5;
    localparam logic [UPC_W-1:0] A_DISPATCH = 4'd6;
    localparam logic [UPC_W-1:0] A_DATA     = 4'd7;
    localparam logic [UPC_W-1:0] A_ALIGN1   = 4'd8;
    localparam logic [UPC_W-1:0] A_FINAL    = 4'd9;
    localparam logic [UPC_W-1:0] A_OUT      = 4'd10;
    localparam logic [UPC_W-1:0] A_UNKEY    = 4'd11;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        begin
            case (addr)
                A_IDLE:     w = '{OP_NOP,   C_WAIT_ITEM, LIM_BYTES, A_IDLE};
                A_CHKKEY:   w = '{OP_NOP,   C_KEYED,     LIM_BYTES, A_DISPATCH};
                A_LOAD:     w = '{OP_LOAD,  C_NEXT,      LIM_BYTES, A_IDLE};
                A_KSUM:     w = '{OP_KSUM,  C_LOOP,      LIM_BYTES, A_KSUM};
                A_SCHED:    w = '{OP_SCHED, C_LOOP,      LIM_SCHED, A_SCHED};
                A_ALIGN0:   w = '{OP_ALIGN, C_HD_NZ,     LIM_BYTES, A_ALIGN0};
                A_DISPATCH: w = '{OP_NOP,   C_END,       LIM_BYTES, A_ALIGN1};
                A_DATA:     w = '{OP_DATA,  C_ALWAYS,    LIM_BYTES, A_IDLE};
                A_ALIGN1:   w = '{OP_ALIGN, C_HD_NZ,     LIM_BYTES, A_ALIGN1};
                A_FINAL:    w = '{OP_FINAL, C_LOOP,      LIM_FINAL, A_FINAL};
                A_OUT:      w = '{OP_OUT,   C_OUT_LOOP,  LIM_BYTES, A_OUT};
                A_UNKEY:    w = '{OP_UNKEY, C_ALWAYS,    LIM_BYTES, A_IDLE};
                default:    w = '{OP_NOP,   C_ALWAYS,    LIM_BYTES, A_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

>>> hw/rtl/keyed_byte_stream_mac_unit.sv
// Keyed 16-byte MAC over a byte stream. The user must write the 128-bit key through the cfg
// channel (index 0 bytes 0..7, index 1 bytes 8..15) only while the unit is idle; the block
// itself leaves this unenforced. An input item with tuser 0 absorbs the byte in tdata; tuser
// 1 ends the message and the unit returns the 16 MAC bytes, byte 0 first, tlast on byte 15.
// Control is a small microprogram stepping a datapath of three rotating 16-byte register
// lines, so all work is done one position per cycle, the output loop pausing under output
// back-pressure. A data item runs the key check, dispatch and data step before the next
// ready. The first item of a message first loads the key and runs the key sum, the key
// schedule and a realignment of the lines. An end item realigns the lines, runs the 32
// finalisation rounds and returns the 16 output items, pausing while tready is held low.
module keyed_byte_stream_mac_unit #(
    parameter int SCHEDULE_ROUNDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // mac_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    kbm_pkg::dp_ctrl_t   ctrl;
    kbm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    kbm_sequencer #(
        .SCHEDULE_ROUNDS(SCHEDULE_ROUNDS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .ctrl    (ctrl)
    );

    kbm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .status   (status),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_byte (m_tdata),
        .out_last (m_tlast)
    );

endmodule

>>> hw/rtl/kbm_sequencer.sv
module kbm_sequencer #(
    parameter int SCHEDULE_ROUNDS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kbm_pkg::dp_status_t status,
    output kbm_pkg::dp_ctrl_t   ctrl
);

    localparam int LOOP_MAX = (SCHEDULE_ROUNDS > 2 * kbm_pkg::MAC_BYTES)
                              ? SCHEDULE_ROUNDS : 2 * kbm_pkg::MAC_BYTES;
    localparam int CW = $clog2(LOOP_MAX);

    localparam logic [CW-1:0] LIM_BYTES_V = CW'(kbm_pkg::MAC_BYTES - 1);
    localparam logic [CW-1:0] LIM_SCHED_V = CW'(SCHEDULE_ROUNDS - 1);
    localparam logic [CW-1:0] LIM_FINAL_V = CW'(2 * kbm_pkg::MAC_BYTES - 1);

    logic [kbm_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    kbm_pkg::ucode_t           word;
    logic [CW-1:0]             lim_val;
    logic                      at_lim;
    logic [kbm_pkg::UPC_W-1:0] upc_inc;

    assign word    = kbm_pkg::ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    always_comb
    begin
        case (word.lim)
            kbm_pkg::LIM_BYTES: lim_val = LIM_BYTES_V;
            kbm_pkg::LIM_SCHED: lim_val = LIM_SCHED_V;
            kbm_pkg::LIM_FINAL: lim_val = LIM_FINAL_V;
            default:            lim_val = LIM_BYTES_V;
        endcase
    end

    assign at_lim   = (cnt_reg == lim_val);
    assign in_ready = (word.cond == kbm_pkg::C_WAIT_ITEM);

    always_comb
    begin
        upc_next = upc_inc;
        cnt_next = cnt_reg;
        case (word.cond)
            kbm_pkg::C_NEXT:      upc_next = upc_inc;
            kbm_pkg::C_ALWAYS:    upc_next = word.target;
            kbm_pkg::C_WAIT_ITEM: upc_next = in_valid ? upc_inc : word.target;
            kbm_pkg::C_KEYED:     upc_next = status.keyed ? word.target : upc_inc;
            kbm_pkg::C_END:
                upc_next = (status.kind == kbm_pkg::KIND_END) ? word.target : upc_inc;
            kbm_pkg::C_HD_NZ:     upc_next = status.hd_zero ? upc_inc : word.target;
            kbm_pkg::C_LOOP:
            begin
                if (at_lim)
                begin
                    upc_next = upc_inc;
                    cnt_next = '0;
                end
                else
                begin
                    upc_next = word.target;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kbm_pkg::C_OUT_LOOP:
            begin
                if (status.out_stall)
                begin
                    upc_next = upc_reg;
                end
                else if (at_lim)
                begin
                    upc_next = upc_inc;
                    cnt_next = '0;
                end
                else
                begin
                    upc_next = word.target;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:              upc_next = kbm_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= kbm_pkg::A_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.n8   = 8'(cnt_reg);
    assign ctrl.last = at_lim;
    assign ctrl.take = in_ready & in_valid;

endmodule

>>> hw/rtl/kbm_datapath.sv
module kbm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kbm_pkg::dp_ctrl_t   ctrl,
    output kbm_pkg::dp_status_t status,
    input  logic                in_kind,
    input  logic [7:0]          in_byte,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    localparam int N = kbm_pkg::MAC_BYTES;

    // three rotating register lines; slot 0 always holds position hd_reg
    logic [7:0] ks_reg  [N];
    logic [7:0] ks_next [N];
    logic [7:0] sum_reg [N];
    logic [7:0] sum_next[N];
    logic [7:0] mac_reg [N];
    logic [7:0] mac_next[N];

    logic [7:0]                mix_reg, mix_next;
    logic [kbm_pkg::POS_W-1:0] hd_reg, hd_next;
    logic                      keyed_reg, keyed_next;
    logic [63:0]               key_low_reg, key_high_reg;
    kbm_pkg::kind_t            kind_reg;
    logic [7:0]                byte_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;

    logic       stall;
    logic [7:0] adv_k, adv_mix, adv_out, sched_mix, dv, d_sum, d_mac;
    logic       rotate;
    logic [7:0] ks_head, sum_head, mac_head;

    assign stall = out_valid_reg & ~out_ready;

    // keystate advance at the head slot
    assign adv_k     = ks_reg[0] + ks_reg[1] + mix_reg;
    assign adv_mix   = mix_reg + adv_k;
    assign adv_out   = (adv_mix + adv_k) ^ adv_k;
    assign sched_mix = mix_reg + adv_k + ctrl.n8;
    assign dv        = adv_out ^ byte_reg;
    assign d_sum     = sum_reg[0] + byte_reg;
    assign d_mac     = (mac_reg[0] + dv) ^ d_sum;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            ks_next[k]  = ks_reg[k];
            sum_next[k] = sum_reg[k];
            mac_next[k] = mac_reg[k];
        end
        mix_next   = mix_reg;
        hd_next    = hd_reg;
        keyed_next = keyed_reg;
        rotate     = 1'b0;
        ks_head    = ks_reg[0];
        sum_head   = sum_reg[0];
        mac_head   = mac_reg[0];

        case (ctrl.op)
            kbm_pkg::OP_LOAD:
            begin
                for (int k = 0; k < N / 2; k++)
                begin
                    ks_next[k]         = key_low_reg[k*8 +: 8];
                    ks_next[k + N / 2] = key_high_reg[k*8 +: 8];
                end
                for (int k = 0; k < N; k++)
                begin
                    sum_next[k] = 8'd0;
                    mac_next[k] = 8'd0;
                end
                mix_next   = 8'd0;
                hd_next    = '0;
                keyed_next = 1'b1;
            end
            kbm_pkg::OP_KSUM:
            begin
                mix_next = mix_reg + ks_reg[0];
                rotate   = 1'b1;
            end
            kbm_pkg::OP_SCHED:
            begin
                ks_head  = adv_k;
                mix_next = sched_mix;
                rotate   = 1'b1;
            end
            kbm_pkg::OP_ALIGN: rotate = (hd_reg != '0);
            kbm_pkg::OP_DATA:
            begin
                ks_head  = adv_k;
                mix_next = adv_mix;
                sum_head = d_sum;
                mac_head = d_mac;
                rotate   = 1'b1;
            end
            kbm_pkg::OP_FINAL:
            begin
                ks_head  = adv_k;
                mix_next = adv_mix;
                mac_head = mac_reg[0] ^ adv_out;
                rotate   = 1'b1;
            end
            kbm_pkg::OP_OUT:   rotate = ~stall;
            kbm_pkg::OP_UNKEY: keyed_next = 1'b0;
            default:           rotate = 1'b0;
        endcase

        if (rotate)
        begin
            for (int k = 0; k < N - 1; k++)
            begin
                ks_next[k]  = ks_reg[k + 1];
                sum_next[k] = sum_reg[k + 1];
                mac_next[k] = mac_reg[k + 1];
            end
            ks_next[N - 1]  = ks_head;
            sum_next[N - 1] = sum_head;
            mac_next[N - 1] = mac_head;
            hd_next         = hd_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = stall;
        if (ctrl.op == kbm_pkg::OP_OUT && !stall)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_reg        <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
        end
        else
        begin
            hd_reg        <= hd_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (kbm_pkg::reg_idx_t'(cfg_index))
                    kbm_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    kbm_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                    default:               key_low_reg  <= key_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            ks_reg[k]  <= ks_next[k];
            sum_reg[k] <= sum_next[k];
            mac_reg[k] <= mac_next[k];
        end
        mix_reg <= mix_next;
        if (ctrl.take)
        begin
            kind_reg <= kbm_pkg::kind_t'(in_kind);
            byte_reg <= in_byte;
        end
        if (ctrl.op == kbm_pkg::OP_OUT && !stall)
        begin
            out_byte_reg <= mac_reg[0];
            out_last_reg <= ctrl.last;
        end
    end

    assign status.keyed     = keyed_reg;
    assign status.kind      = kind_reg;
    assign status.hd_zero   = (hd_reg == '0);
    assign status.out_stall = stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule
